// ===== rtl/r2fft_pkg.sv =====
// Shared types, constants and helper functions for the radix-2 FFT block.
`timescale 1ns / 1ps
package r2fft_pkg;

  // Sizes of the point store and of the arithmetic.
  localparam int MAX_POINTS = 1024;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int LOG_W      = 4;
  localparam int SAMPLE_W   = 16;
  localparam int DATA_W     = 28;
  localparam int TW_FRAC    = 16;
  localparam int TW_W       = TW_FRAC + 2;
  localparam int ROM_DEPTH  = MAX_POINTS / 4 + 1;
  localparam int TWI_W      = ADDR_W - 1;
  localparam int PROD_W     = TW_W + DATA_W;
  localparam int TR_W       = PROD_W + 1 - TW_FRAC;
  localparam int SUM_W      = TR_W + 1;
  localparam int CFG_IDX_W  = 1;

  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

  // Opcodes of an input item.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 1'b1;

  // One input item.
  typedef struct packed {
    logic                       opcode;
    logic signed [SAMPLE_W-1:0] sample_real;
    logic signed [SAMPLE_W-1:0] sample_imag;
  } item_t;

  // One result item.
  typedef struct packed {
    logic                     valid_res;
    logic signed [DATA_W-1:0] result_real;
    logic signed [DATA_W-1:0] result_imag;
    logic [ADDR_W-1:0]        point_index;
    logic                     last_point;
  } result_t;

  // Source of the data written into the point store.
  typedef enum logic [2:0] {
    WSRC_SAMPLE,
    WSRC_PORT_A,
    WSRC_PORT_B,
    WSRC_BF_TOP,
    WSRC_BF_BOT,
    WSRC_SCALE
  } wr_src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              capture;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic [TWI_W-1:0]  tw_idx;
    logic              mul_en;
    logic              sum_en;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    wr_src_t           wr_src;
    logic              inverse;
    logic [LOG_W-1:0]  log2_len;
    logic              point_sel;
    logic [ADDR_W-1:0] point_index;
    logic              point_last;
  } dp_cmd_t;

  typedef logic signed [TW_W-1:0] cos_rom_t [ROM_DEPTH];

  // Unsigned 64-bit quotient by shift and subtract, used only while building the table.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    logic [64:0]     rem;
    longint unsigned quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave cosine table in Q2.16, built by an integer Taylor series in Q30.
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t          rom;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   t;
    longint            sum;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      x   = (longint'(i) * TWO_PI_Q30 + MAX_POINTS / 2) / MAX_POINTS;
      x2  = (x * x + (64'd1 << 29)) >> 30;
      t   = 64'd1 << 30;
      sum = longint'(t);
      for (int n = 0; n < 28; n += 2) begin
        t = udiv64(t * x2, 64'((n + 1) * (n + 2)));
        if (((n / 2) % 2) == 0) begin
          sum = sum - longint'(t);
        end else begin
          sum = sum + longint'(t);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > (64'sd1 <<< 30)) begin
        sum = 64'sd1 <<< 30;
      end
      sum    = (sum + (64'sd1 <<< (29 - TW_FRAC))) >>> (30 - TW_FRAC);
      rom[i] = sum[TW_W-1:0];
    end
    return rom;
  endfunction

  // Bit reversal of an index over the low l bits.
  function automatic logic [ADDR_W-1:0] bit_rev(input logic [ADDR_W-1:0] i,
                                                input logic [LOG_W-1:0]  l);
    logic [ADDR_W-1:0] r;
    for (int s = 0; s < ADDR_W; s++) begin
      r[ADDR_W-1-s] = i[s];
    end
    return r >> (LOG_W'(ADDR_W) - l);
  endfunction

  // Saturation of a butterfly sum to the store width.
  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'((64'sd1 <<< (DATA_W - 1)) - 1);
    lo = -hi - 1;
    if (v > hi) begin
      return hi[DATA_W-1:0];
    end else if (v < lo) begin
      return lo[DATA_W-1:0];
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

// ===== rtl/r2fft_dp.sv =====
// Datapath of the FFT: point store, twiddle table, butterfly arithmetic and scaling.
`timescale 1ns / 1ps
module r2fft_dp (
  input  logic               clk,
  input  r2fft_pkg::dp_cmd_t dp_cmd,
  input  r2fft_pkg::item_t   command,
  output r2fft_pkg::result_t result
);
  import r2fft_pkg::*;

  localparam cos_rom_t COS_ROM = build_cos_rom();
  localparam logic [ADDR_W-1:0] QUARTER = ADDR_W'(ROM_DEPTH - 1);
  localparam logic signed [PROD_W:0] RND = (PROD_W + 1)'(1) <<< (TW_FRAC - 1);

  logic [2*DATA_W-1:0] mem [MAX_POINTS];
  logic [2*DATA_W-1:0] data_a;
  logic [2*DATA_W-1:0] data_b;
  logic [2*DATA_W-1:0] wr_data;

  item_t sample_q;

  logic [ADDR_W-1:0]     m_ext;
  logic [ADDR_W-1:0]     c_pos;
  logic [ADDR_W-1:0]     s_pos;
  logic signed [TW_W-1:0] c_val;
  logic signed [TW_W-1:0] s_val;
  logic signed [TW_W-1:0] tw_c;
  logic signed [TW_W-1:0] tw_wi;

  logic signed [DATA_W-1:0] ur;
  logic signed [DATA_W-1:0] ui;
  logic signed [DATA_W-1:0] xr;
  logic signed [DATA_W-1:0] xi;

  logic signed [PROD_W-1:0] p_cxr;
  logic signed [PROD_W-1:0] p_wxi;
  logic signed [PROD_W-1:0] p_cxi;
  logic signed [PROD_W-1:0] p_wxr;
  logic signed [PROD_W:0]   vr;
  logic signed [PROD_W:0]   vi;
  logic signed [TR_W-1:0]   tr;
  logic signed [TR_W-1:0]   ti;

  logic signed [SUM_W-1:0]  top_r;
  logic signed [SUM_W-1:0]  top_i;
  logic signed [SUM_W-1:0]  bot_r;
  logic signed [SUM_W-1:0]  bot_i;
  logic signed [DATA_W:0]   sc_r;
  logic signed [DATA_W:0]   sc_i;
  logic signed [DATA_W:0]   sh_r;
  logic signed [DATA_W:0]   sh_i;
  logic signed [DATA_W-1:0] ext_r;
  logic signed [DATA_W-1:0] ext_i;

  assign ur = data_a[2*DATA_W-1:DATA_W];
  assign ui = data_a[DATA_W-1:0];
  assign xr = data_b[2*DATA_W-1:DATA_W];
  assign xi = data_b[DATA_W-1:0];

  // Sample capture on an accepted transfer.
  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      sample_q <= command;
    end
  end

  // Twiddle lookup by quadrant symmetry.
  always_comb begin
    m_ext = {1'b0, dp_cmd.tw_idx};
    if (m_ext <= QUARTER) begin
      c_pos = m_ext;
      s_pos = QUARTER - m_ext;
    end else begin
      c_pos = (QUARTER << 1) - m_ext;
      s_pos = m_ext - QUARTER;
    end
    if (m_ext <= QUARTER) begin
      c_val = COS_ROM[c_pos[TWI_W-1:0]];
    end else begin
      c_val = -COS_ROM[c_pos[TWI_W-1:0]];
    end
    s_val = COS_ROM[s_pos[TWI_W-1:0]];
  end

  // Store reads and twiddle register.
  always_ff @(posedge clk) begin
    if (dp_cmd.rd_en) begin
      data_a <= mem[dp_cmd.rd_addr_a];
      data_b <= mem[dp_cmd.rd_addr_b];
      tw_c   <= c_val;
      tw_wi  <= dp_cmd.inverse ? s_val : -s_val;
    end
  end

  // Complex multiply, one register after the products.
  always_ff @(posedge clk) begin
    if (dp_cmd.mul_en) begin
      p_cxr <= tw_c * xr;
      p_wxi <= tw_wi * xi;
      p_cxi <= tw_c * xi;
      p_wxr <= tw_wi * xr;
    end
  end

  // Rounding of the product sums to nearest, half up.
  always_comb begin
    vr = (PROD_W + 1)'(p_cxr) - (PROD_W + 1)'(p_wxi) + RND;
    vi = (PROD_W + 1)'(p_cxi) + (PROD_W + 1)'(p_wxr) + RND;
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.sum_en) begin
      tr <= TR_W'(vr >>> TW_FRAC);
      ti <= TR_W'(vi >>> TW_FRAC);
    end
  end

  // Butterfly outputs, inverse scaling and write data selection.
  always_comb begin
    top_r = SUM_W'(ur) + SUM_W'(tr);
    top_i = SUM_W'(ui) + SUM_W'(ti);
    bot_r = SUM_W'(ur) - SUM_W'(tr);
    bot_i = SUM_W'(ui) - SUM_W'(ti);
    sc_r  = (DATA_W + 1)'(ur);
    sc_i  = (DATA_W + 1)'(ui);
    sc_r  = sc_r + ((DATA_W + 1)'(1) << (dp_cmd.log2_len - 1'b1));
    sc_i  = sc_i + ((DATA_W + 1)'(1) << (dp_cmd.log2_len - 1'b1));
    sh_r  = sc_r >>> dp_cmd.log2_len;
    sh_i  = sc_i >>> dp_cmd.log2_len;
    ext_r = {{(DATA_W - SAMPLE_W){sample_q.sample_real[SAMPLE_W-1]}}, sample_q.sample_real};
    ext_i = {{(DATA_W - SAMPLE_W){sample_q.sample_imag[SAMPLE_W-1]}}, sample_q.sample_imag};
    case (dp_cmd.wr_src)
      WSRC_SAMPLE: wr_data = {ext_r, ext_i};
      WSRC_PORT_A: wr_data = data_a;
      WSRC_PORT_B: wr_data = data_b;
      WSRC_BF_TOP: wr_data = {sat_data(top_r), sat_data(top_i)};
      WSRC_BF_BOT: wr_data = {sat_data(bot_r), sat_data(bot_i)};
      WSRC_SCALE:  wr_data = {sh_r[DATA_W-1:0], sh_i[DATA_W-1:0]};
      default:     wr_data = data_a;
    endcase
  end

  // Store write port.
  always_ff @(posedge clk) begin
    if (dp_cmd.wr_en) begin
      mem[dp_cmd.wr_addr] <= wr_data;
    end
  end

  // Result assembly from the fetched point.
  always_comb begin
    result = '0;
    if (dp_cmd.point_sel) begin
      result.valid_res   = 1'b1;
      result.result_real = ur;
      result.result_imag = ui;
      result.point_index = dp_cmd.point_index;
      result.last_point  = dp_cmd.point_last;
    end
  end

endmodule

// ===== rtl/r2fft_ctrl.sv =====
// Controller of the FFT: handshake, counters, configuration and transform sequencing.
`timescale 1ns / 1ps
module r2fft_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                opcode,
  input  logic                                cfg_we,
  input  logic [r2fft_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [r2fft_pkg::LOG_W-1:0]         cfg_data,
  output logic                                busy,
  output logic                                done,
  output r2fft_pkg::dp_cmd_t                  dp_cmd
);
  import r2fft_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_LOAD  = 14'b00000000000010,
    S_FETCH = 14'b00000000000100,
    S_RESP  = 14'b00000000001000,
    S_PRD   = 14'b00000000010000,
    S_PWA   = 14'b00000000100000,
    S_PWB   = 14'b00000001000000,
    S_BRD   = 14'b00000010000000,
    S_BMUL  = 14'b00000100000000,
    S_BSUM  = 14'b00001000000000,
    S_BWA   = 14'b00010000000000,
    S_BWB   = 14'b00100000000000,
    S_SRD   = 14'b01000000000000,
    S_SWR   = 14'b10000000000000
  } state_t;

  state_t            state;
  logic              inverse;
  logic [LOG_W-1:0]  length_log2;
  logic [CNT_W-1:0]  loaded_count;
  logic [CNT_W-1:0]  fetched_count;
  logic              transform_done;
  logic [ADDR_W-1:0] idx;
  logic [LOG_W-1:0]  stage;
  logic              resp_point;
  logic [ADDR_W-1:0] resp_index;
  logic              resp_last;

  logic [LOG_W-1:0]  eff_l;
  logic [CNT_W-1:0]  n_pts;
  logic [CNT_W-1:0]  half_pts;
  logic [ADDR_W-1:0] rev_idx;
  logic [ADDR_W-1:0] bf_k;
  logic [ADDR_W-1:0] bf_a;
  logic [ADDR_W-1:0] bf_b;
  logic [ADDR_W-1:0] tw_full;
  logic              last_idx;
  logic              last_half;
  logic              last_stage;
  logic [CNT_W-1:0]  load_pos;
  logic [CNT_W-1:0]  load_next;
  logic [CNT_W-1:0]  fetch_next;
  logic              accept;

  assign busy   = (state != S_IDLE);
  assign done   = (state == S_RESP);
  assign accept = start && !busy;

  // Effective length, clamped to the supported range.
  always_comb begin
    if (length_log2 == '0) begin
      eff_l = LOG_W'(1);
    end else if (length_log2 > LOG_W'(ADDR_W)) begin
      eff_l = LOG_W'(ADDR_W);
    end else begin
      eff_l = length_log2;
    end
  end

  // Index arithmetic for the permutation, butterfly and scaling passes.
  always_comb begin
    n_pts      = CNT_W'(1) << eff_l;
    half_pts   = n_pts >> 1;
    rev_idx    = bit_rev(idx, eff_l);
    bf_k       = idx & ((ADDR_W'(1) << stage) - 1'b1);
    bf_a       = ((idx >> stage) << (stage + 1'b1)) | bf_k;
    bf_b       = bf_a | (ADDR_W'(1) << stage);
    tw_full    = bf_k << (LOG_W'(ADDR_W - 1) - stage);
    last_idx   = ({1'b0, idx} == (n_pts - 1'b1));
    last_half  = ({1'b0, idx} == (half_pts - 1'b1));
    last_stage = (stage == (eff_l - 1'b1));
    load_pos   = transform_done ? '0 : loaded_count;
    load_next  = load_pos + 1'b1;
    fetch_next = fetched_count + 1'b1;
  end

  // Datapath commands decoded from the state.
  always_comb begin
    dp_cmd             = '0;
    dp_cmd.wr_src      = WSRC_SAMPLE;
    dp_cmd.capture     = accept;
    dp_cmd.inverse     = inverse;
    dp_cmd.log2_len    = eff_l;
    dp_cmd.point_sel   = resp_point && (state == S_RESP);
    dp_cmd.point_index = resp_index;
    dp_cmd.point_last  = resp_last;
    case (state)
      S_LOAD: begin
        dp_cmd.wr_en   = 1'b1;
        dp_cmd.wr_addr = load_pos[ADDR_W-1:0];
        dp_cmd.wr_src  = WSRC_SAMPLE;
      end
      S_FETCH: begin
        dp_cmd.rd_en     = 1'b1;
        dp_cmd.rd_addr_a = fetched_count[ADDR_W-1:0];
        dp_cmd.rd_addr_b = fetched_count[ADDR_W-1:0];
      end
      S_PRD: begin
        dp_cmd.rd_en     = 1'b1;
        dp_cmd.rd_addr_a = idx;
        dp_cmd.rd_addr_b = rev_idx;
      end
      S_PWA: begin
        dp_cmd.wr_en   = (idx < rev_idx);
        dp_cmd.wr_addr = idx;
        dp_cmd.wr_src  = WSRC_PORT_B;
      end
      S_PWB: begin
        dp_cmd.wr_en   = 1'b1;
        dp_cmd.wr_addr = rev_idx;
        dp_cmd.wr_src  = WSRC_PORT_A;
      end
      S_BRD: begin
        dp_cmd.rd_en     = 1'b1;
        dp_cmd.rd_addr_a = bf_a;
        dp_cmd.rd_addr_b = bf_b;
        dp_cmd.tw_idx    = tw_full[TWI_W-1:0];
      end
      S_BMUL: dp_cmd.mul_en = 1'b1;
      S_BSUM: dp_cmd.sum_en = 1'b1;
      S_BWA: begin
        dp_cmd.wr_en   = 1'b1;
        dp_cmd.wr_addr = bf_a;
        dp_cmd.wr_src  = WSRC_BF_TOP;
      end
      S_BWB: begin
        dp_cmd.wr_en   = 1'b1;
        dp_cmd.wr_addr = bf_b;
        dp_cmd.wr_src  = WSRC_BF_BOT;
      end
      S_SRD: begin
        dp_cmd.rd_en     = 1'b1;
        dp_cmd.rd_addr_a = idx;
        dp_cmd.rd_addr_b = idx;
      end
      S_SWR: begin
        dp_cmd.wr_en   = 1'b1;
        dp_cmd.wr_addr = idx;
        dp_cmd.wr_src  = WSRC_SCALE;
      end
      default: dp_cmd.wr_en = 1'b0;
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      inverse     <= 1'b0;
      length_log2 <= LOG_W'(ADDR_W);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INVERSE: inverse     <= cfg_data[0];
        CFG_LENGTH:  length_log2 <= cfg_data;
        default:     inverse     <= inverse;
      endcase
    end
  end

  // Sequencer and frame counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      loaded_count   <= '0;
      fetched_count  <= '0;
      transform_done <= 1'b0;
      idx            <= '0;
      stage          <= '0;
      resp_point     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (opcode == OP_FETCH) ? S_FETCH : S_LOAD;
          end
        end
        S_LOAD: begin
          transform_done <= 1'b0;
          loaded_count   <= load_next;
          if (transform_done) begin
            fetched_count <= '0;
          end
          if (load_next >= n_pts) begin
            idx   <= '0;
            state <= S_PRD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_FETCH: begin
          resp_point <= transform_done && (fetched_count < n_pts);
          resp_index <= fetched_count[ADDR_W-1:0];
          resp_last  <= (fetched_count == (n_pts - 1'b1));
          if (transform_done) begin
            if (fetched_count >= n_pts) begin
              transform_done <= 1'b0;
              loaded_count   <= '0;
              fetched_count  <= '0;
            end else begin
              if (fetch_next >= n_pts) begin
                transform_done <= 1'b0;
                loaded_count   <= '0;
                fetched_count  <= '0;
              end else begin
                fetched_count <= fetch_next;
              end
            end
          end
          state <= S_RESP;
        end
        S_RESP: state <= S_IDLE;
        S_PRD:  state <= S_PWA;
        S_PWA: begin
          if (idx < rev_idx) begin
            state <= S_PWB;
          end else if (last_idx) begin
            idx   <= '0;
            stage <= '0;
            state <= S_BRD;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_PRD;
          end
        end
        S_PWB: begin
          if (last_idx) begin
            idx   <= '0;
            stage <= '0;
            state <= S_BRD;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_PRD;
          end
        end
        S_BRD:  state <= S_BMUL;
        S_BMUL: state <= S_BSUM;
        S_BSUM: state <= S_BWA;
        S_BWA:  state <= S_BWB;
        S_BWB: begin
          if (!last_half) begin
            idx   <= idx + 1'b1;
            state <= S_BRD;
          end else if (!last_stage) begin
            idx   <= '0;
            stage <= stage + 1'b1;
            state <= S_BRD;
          end else if (inverse) begin
            idx   <= '0;
            state <= S_SRD;
          end else begin
            transform_done <= 1'b1;
            fetched_count  <= '0;
            state          <= S_IDLE;
          end
        end
        S_SRD: state <= S_SWR;
        S_SWR: begin
          if (last_idx) begin
            transform_done <= 1'b1;
            fetched_count  <= '0;
            state          <= S_IDLE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/radix2_complex_fft.sv =====
// Top level of the radix-2 decimation-in-time complex FFT.
// A load transfer passes through the load state; a fetch through the fetch and response
// states, its result strobed on done. The load that completes a frame adds the transform:
// bit reversal (a read per index, two writes per swapped pair), butterflies (read,
// multiply, round, two writes on the single write port) and scaling for the inverse.
// Synchronous reset clears counters, registers and controller state, not the point store.
`timescale 1ns / 1ps
module radix2_complex_fft (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  r2fft_pkg::item_t                command,
  output logic                            done,
  output r2fft_pkg::result_t              result,
  input  logic                            cfg_we,
  input  logic [r2fft_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [r2fft_pkg::LOG_W-1:0]     cfg_data
);
  import r2fft_pkg::*;

  dp_cmd_t dp_cmd;

  r2fft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .opcode    (command.opcode),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .done      (done),
    .dp_cmd    (dp_cmd)
  );

  r2fft_dp u_dp (
    .clk     (clk),
    .dp_cmd  (dp_cmd),
    .command (command),
    .result  (result)
  );

  // A result is only strobed while the block is busy.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done strobed while idle");

  // Every accepted fetch transfer answers with done in the response state after the fetch state.
  a_fetch_resp: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command.opcode == OP_FETCH) |-> ##2 done)
    else $error("fetch transfer without result");

  // A result lasts exactly one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the radix-2 complex FFT: directed table, then random frames.
`timescale 1ns / 1ps
module tb_top;
  import r2fft_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  item_t                command = '0;
  logic                 done;
  result_t              result;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LOG_W-1:0]     cfg_data = '0;

  always #1 clk = ~clk;

  radix2_complex_fft DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predictor state: point store, frame counters and the register copies.
  int      spec_re [MAX_POINTS];
  int      spec_im [MAX_POINTS];
  int      cos_tab [MAX_POINTS/4 + 1];
  int      loaded_cnt;
  int      fetched_cnt;
  bit      frame_ready;
  bit      cur_inv;
  int      cur_len;
  int      settle_cycles = 4;
  int      items;
  int      errors;
  bit      quiet;
  result_t point_q[$];

  // Quarter-wave cosine table in Q2.16 from a Taylor series in Q30.
  function automatic void make_cos_table();
    longint unsigned x, x2, t;
    longint          acc;
    for (int i = 0; i <= MAX_POINTS/4; i++) begin
      x   = (longint'(i) * 64'd6746518852 + MAX_POINTS/2) / MAX_POINTS;
      x2  = (x * x + (64'd1 << 29)) >> 30;
      t   = 64'd1 << 30;
      acc = longint'(t);
      for (int n = 0; n < 28; n += 2) begin
        t = t * x2 / longint'((n + 1) * (n + 2));
        if ((n / 2) % 2 == 0) acc -= longint'(t);
        else acc += longint'(t);
      end
      if (acc < 0) acc = 0;
      if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
      cos_tab[i] = int'((acc + (64'sd1 <<< 13)) >>> 14);
    end
  endfunction

  function automatic longint clamp28(input longint v);
    if (v > 134217727) return 134217727;
    if (v < -134217728) return -134217728;
    return v;
  endfunction

  // Round half up at bit sh, which an arithmetic shift turns into a floor.
  function automatic longint round_sh(input longint v, input int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic int span_log2();
    if (cur_len < 1) return 1;
    if (cur_len > 10) return 10;
    return cur_len;
  endfunction

  // In-place transform of the first 2^L points of the predicted store.
  task automatic transform_store();
    int     lg, n, r, a, b, hh, stride, m, q;
    longint c, sn, wi, xr, xi, tr, ti, ur, ui;
    lg = span_log2();
    n  = 1 << lg;
    q  = MAX_POINTS / 4;
    for (int i = 0; i < n; i++) begin
      r = 0;
      for (int s = 0; s < lg; s++) r |= ((i >> s) & 1) << (lg - 1 - s);
      if (i < r) begin
        a = spec_re[i]; b = spec_im[i];
        spec_re[i] = spec_re[r]; spec_im[i] = spec_im[r];
        spec_re[r] = a; spec_im[r] = b;
      end
    end
    for (int s = 0; s < lg; s++) begin
      hh     = 1 << s;
      stride = MAX_POINTS >> (s + 1);
      for (int j = 0; j < n; j += 2 * hh) begin
        for (int k = 0; k < hh; k++) begin
          m = k * stride;
          if (m <= q) begin
            c  = cos_tab[m];
            sn = cos_tab[q - m];
          end else begin
            c  = -cos_tab[(2 * q - m) % (q + 1)];
            sn = cos_tab[(m - q) % (q + 1)];
          end
          wi = cur_inv ? sn : -sn;
          a  = j + k;
          b  = a + hh;
          xr = spec_re[b]; xi = spec_im[b];
          tr = round_sh(c * xr - wi * xi, TW_FRAC);
          ti = round_sh(c * xi + wi * xr, TW_FRAC);
          ur = spec_re[a]; ui = spec_im[a];
          spec_re[a] = int'(clamp28(ur + tr));
          spec_im[a] = int'(clamp28(ui + ti));
          spec_re[b] = int'(clamp28(ur - tr));
          spec_im[b] = int'(clamp28(ui - ti));
        end
      end
    end
    if (cur_inv) begin
      for (int i = 0; i < n; i++) begin
        spec_re[i] = int'(clamp28(round_sh(spec_re[i], lg)));
        spec_im[i] = int'(clamp28(round_sh(spec_im[i], lg)));
      end
    end
    settle_cycles = 6 * n * (lg + 1) + 100;
  endtask

  task automatic close_frame();
    frame_ready = 1'b0;
    loaded_cnt  = 0;
    fetched_cnt = 0;
  endtask

  // Updates the predicted state for one accepted transfer and queues its point.
  task automatic predict_item(input item_t it);
    int      n;
    result_t pt;
    n  = 1 << span_log2();
    pt = '0;
    if (it.opcode == OP_LOAD) begin
      if (frame_ready) close_frame();
      spec_re[loaded_cnt % MAX_POINTS] = it.sample_real;
      spec_im[loaded_cnt % MAX_POINTS] = it.sample_imag;
      loaded_cnt++;
      if (loaded_cnt >= n) begin
        transform_store();
        frame_ready = 1'b1;
        fetched_cnt = 0;
      end
      return;
    end
    if (frame_ready && fetched_cnt >= n) begin
      close_frame();
    end else if (frame_ready) begin
      pt.valid_res   = 1'b1;
      pt.result_real = spec_re[fetched_cnt][DATA_W-1:0];
      pt.result_imag = spec_im[fetched_cnt][DATA_W-1:0];
      pt.point_index = fetched_cnt[ADDR_W-1:0];
      pt.last_point  = (fetched_cnt == n - 1);
      fetched_cnt++;
      if (fetched_cnt >= n) close_frame();
    end
    point_q.push_back(pt);
  endtask

  function automatic int pick_gap();
    if (quiet || items > 1000) return 0;
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
  endfunction

  // Presents one item and holds it until the block takes the transfer.
  task automatic issue(input item_t it, input bit zero_point);
    int gap;
    start   <= 1'b1;
    command <= it;
    do @(posedge clk); while (busy);
    predict_item(it);
    if (zero_point) point_q[$] = '0;
    items++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drains outstanding points and lets any transform in progress finish.
  task automatic wait_idle();
    start <= 1'b0;
    while (point_q.size() != 0) @(posedge clk);
    repeat (settle_cycles) @(posedge clk);
    settle_cycles = 4;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= LOG_W'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_INVERSE) cur_inv = val[0];
    else cur_len = val & 15;
  endtask

  function automatic item_t make_load();
    item_t it;
    it.opcode = OP_LOAD;
    case ($urandom_range(0, 7))
      0: begin
        it.sample_real = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        it.sample_imag = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      end
      default: begin
        it.sample_real = 16'($urandom);
        it.sample_imag = 16'($urandom);
      end
    endcase
    return it;
  endfunction

  function automatic item_t make_fetch();
    return item_t'{OP_FETCH, 16'($urandom), 16'($urandom)};
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Every strobed point is matched against the oldest predicted one.
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (point_q.size() == 0) begin
        $display("%0t: unexpected point, expected none, actual %p", $time, result);
        errors++;
      end else begin
        want = point_q.pop_front();
        check_field("valid_res", want.valid_res, result.valid_res);
        check_field("result_real", want.result_real, result.result_real);
        check_field("result_imag", want.result_imag, result.result_imag);
        check_field("point_index", want.point_index, result.point_index);
        check_field("last_point", want.last_point, result.last_point);
      end
    end
  end

  // Directed rows; a set zero flag means the point is known to be all zeros.
  typedef struct {
    logic op;
    int   re;
    int   im;
    bit   zero;
  } row_t;

  row_t rows [15] = '{
    '{OP_FETCH, 0, 0, 1},            // fetch with nothing transformed
    '{OP_LOAD, 32767, -32768, 0},
    '{OP_LOAD, -32768, 32767, 0},
    '{OP_FETCH, 0, 0, 0},
    '{OP_FETCH, 0, 0, 0},
    '{OP_FETCH, -1, -1, 1},          // past the end: frame already closed
    '{OP_LOAD, 0, 0, 0},
    '{OP_FETCH, 0, 0, 1},            // frame only half loaded
    '{OP_LOAD, -1, -1, 0},
    '{OP_FETCH, 0, 0, 0},
    '{OP_LOAD, 32767, 32767, 0},     // new frame drops the unread point
    '{OP_LOAD, -32768, -32768, 0},
    '{OP_FETCH, 0, 0, 0},
    '{OP_FETCH, 0, 0, 0},
    '{OP_FETCH, 0, 0, 1}
  };

  initial begin
    int lenv, nf, pick, phase;
    bit shrunk;
    make_cos_table();
    cur_inv = 1'b0;
    cur_len = 10;
    close_frame();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, forward at length two, then inverse with the length below range.
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) begin
        wait_idle();
        write_reg(CFG_INVERSE, 1);
        write_reg(CFG_LENGTH, 0);
      end
      foreach (rows[i]) begin
        issue(item_t'{rows[i].op, 16'(rows[i].re), 16'(rows[i].im)}, rows[i].zero);
        if (i == 0 && pass == 0) begin
          wait_idle();
          write_reg(CFG_LENGTH, 1);
        end
      end
    end

    // Random frames; one uses the length above range as the largest transform.
    phase = 0;
    while (items < 1150) begin
      phase++;
      quiet = ($urandom_range(0, 4) == 0);
      wait_idle();
      write_reg(CFG_INVERSE, $urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      if (phase == 3) lenv = 15;
      else if (pick < 8) lenv = $urandom_range(1, 5);
      else lenv = $urandom_range(0, 7);
      write_reg(CFG_LENGTH, lenv);
      if ($urandom_range(0, 5) == 0) issue(make_fetch(), 0);
      shrunk = 0;
      do begin
        issue(make_load(), 0);
        if (phase != 3 && !shrunk && !frame_ready && $urandom_range(0, 15) == 0) begin
          // change the length part-way through loading
          shrunk = 1;
          wait_idle();
          write_reg(CFG_LENGTH, $urandom_range(0, lenv));
        end
      end while (!frame_ready);
      nf   = 1 << span_log2();
      pick = $urandom_range(0, 7);
      if (pick == 0) nf = $urandom_range(0, nf - 1);
      else if (pick == 1) nf += $urandom_range(1, 2);
      // The largest frame is only partly read back to keep the run near its item budget.
      if (phase == 3 && nf > 64) nf = 64;
      repeat (nf) issue(make_fetch(), 0);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #4000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/r2fft_pkg.sv
rtl/r2fft_dp.sv
rtl/r2fft_ctrl.sv
rtl/radix2_complex_fft.sv
dv/tb_top.sv
